// ===== src/cpps_pkg.sv =====
// ----------------------------------------------------------------------------
// cpps_pkg
// shared types and constants of the capacity priority scheduler
// ----------------------------------------------------------------------------
package cpps_pkg;

  localparam logic [11:0] TICK_MAX = 12'hFFF;
  localparam logic [11:0] CAP_RESET = 12'd20;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // register indexes
  localparam logic [0:0] REG_CAPACITY = 1'b0;
  localparam logic [0:0] REG_TASK_COUNT = 1'b1;

  // task states
  localparam logic [1:0] ST_WAIT = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [3:0]  task_id;
    logic [7:0]  priority_req;
    logic [11:0] start_time;
    logic [11:0] finish_time;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  task_index;
    logic [1:0]  task_state;
    logic [11:0] current_finish;
    logic [11:0] idle_ticks;
    logic [11:0] load_now;
    logic        all_done;
    logic        last_row;
  } out_item_t;

  // task table entry: priority, start, finish, idle
  typedef struct packed {
    logic [7:0]  prio;
    logic [11:0] start;
    logic [11:0] finish;
    logic [11:0] idle;
  } task_ent_t;

endpackage

// ===== src/cpps_ram.sv =====
// ----------------------------------------------------------------------------
// cpps_ram
// generic simple dual port synchronous ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module cpps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/capacity_priority_preempt_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// capacity_priority_preempt_scheduler_top
// tick driven priority scheduler with capacity limit and preemption
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    cpps_pkg::in_item_t
// out      output     out_valid/out_ready  cpps_pkg::out_item_t
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a load is the transfer, then the write of one task entry
// a tick reads each task it needs from the task table, one memory access per
// read; the insertion sort and the eviction scan compare over register lists
// after reset the task table is cleared one entry a cycle, MAX_TASKS entries
// result rows leave through the output register, each after its read of the
// task table; a stalled output holds the sequencer
// ----------------------------------------------------------------------------
module capacity_priority_preempt_scheduler_top #(
  parameter int MAX_TASKS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cpps_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cpps_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [11:0]          cfg_data
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int LW = $clog2(2 * MAX_TASKS);
  localparam int LCW = $clog2(2 * MAX_TASKS + 1);
  localparam int EW = $bits(cpps_pkg::task_ent_t);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LD_WR,
    S_ALV_RD, S_ALV_CHK,
    S_RET_RD, S_RET_CHK,
    S_CND_PEND, S_CND_RD, S_CND_CHK,
    S_SRT_I, S_SRT_KEY, S_SRT_RD, S_SRT_CMP,
    S_ADM_RD, S_ADM_CHK, S_ADM_SCAN,
    S_ADM_SRD, S_ADM_SCMP, S_ADM_EVICT,
    S_IDL_RD, S_IDL_CHK,
    S_OUT_RD, S_OUT_WAIT, S_OUT_SEND
  } state_t;

  state_t state_r;

  // configuration
  logic [11:0] cap_r;
  logic [4:0]  tcnt_r;

  // task table in one memory
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  cpps_pkg::task_ent_t mem_wdata, mem_rdata;

  cpps_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_task_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // run, pend and candidate lists, with priorities for the run and candidate lists
  logic [IW-1:0] run_id_r  [MAX_TASKS];
  logic [7:0]    run_pr_r  [MAX_TASKS];
  logic [CW-1:0] run_cnt_r;
  logic [IW-1:0] pend_id_r [MAX_TASKS];
  logic [CW-1:0] pend_cnt_r;
  logic [IW-1:0] cand_id_r [2*MAX_TASKS];
  logic [7:0]    cand_pr_r [2*MAX_TASKS];
  logic [LCW-1:0] cand_cnt_r;
  logic [31:0]   load_r;
  logic [11:0]   now_r;
  logic          alive_r;

  // sequencing
  logic [LCW-1:0] i_r, j_r;
  logic [CW-1:0]  ws_r;
  logic [IW-1:0]  key_id_r, vic_id_r;
  logic [7:0]     key_pr_r, vic_pr_r;
  logic [CW-1:0]  vic_pos_r;
  cpps_pkg::in_item_t ld_r;
  cpps_pkg::out_item_t out_r;
  logic out_valid_r;

  // window size: clamp task count to 1..MAX_TASKS
  logic [CW-1:0] ws_c;
  always_comb begin
    if (tcnt_r == 5'd0) ws_c = CW'(1);
    else if (32'(tcnt_r) > MAX_TASKS) ws_c = CW'(MAX_TASKS);
    else ws_c = CW'(tcnt_r);
  end

  // membership searches over the small lists
  function automatic logic in_run(input logic [IW-1:0] id,
                                  input logic [CW-1:0] cnt,
                                  input logic [IW-1:0] ids [MAX_TASKS]);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < MAX_TASKS; k++) begin
      if (k < 32'(cnt) && ids[k] == id) hit = 1'b1;
    end
    return hit;
  endfunction

  logic [IW-1:0] cur_id;
  assign cur_id = IW'(i_r);

  logic [IW-1:0] cand_cur;
  assign cand_cur = cand_id_r[LW'(i_r)];

  logic cur_running;
  assign cur_running = in_run(cand_cur, run_cnt_r, run_id_r);
  logic row_running;
  assign row_running = in_run(cur_id, run_cnt_r, run_id_r);

  logic cur_pending;
  logic [CW-1:0] cur_pend_pos;
  always_comb begin
    cur_pending = 1'b0;
    cur_pend_pos = '0;
    for (int k = 0; k < MAX_TASKS; k++) begin
      if (k < 32'(pend_cnt_r) && pend_id_r[k] == cand_cur && !cur_pending) begin
        cur_pending = 1'b1;
        cur_pend_pos = CW'(k);
      end
    end
  end

  logic vic_pending;
  assign vic_pending = in_run(vic_id_r, pend_cnt_r, pend_id_r);

  // summed load wraps at 32 bits
  logic [31:0] need;
  assign need = load_r + 32'(key_pr_r);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) || (state_r == S_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = cur_id;
    mem_wdata = mem_rdata;
    mem_raddr = cur_id;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wdata = '0;
      end
      S_LD_WR: begin
        mem_we = 1'b1;
        mem_waddr = key_id_r;
        mem_wdata.prio = ld_r.priority_req;
        mem_wdata.start = ld_r.start_time;
        mem_wdata.finish = ld_r.finish_time;
        mem_wdata.idle = '0;
      end
      S_RET_RD: mem_raddr = run_id_r[IW'(i_r - 1'b1)];
      S_CND_RD: mem_raddr = IW'(i_r - 1'b1);
      S_SRT_I: mem_raddr = cand_cur;
      S_ADM_RD: mem_raddr = cand_cur;
      S_IDL_RD: mem_raddr = pend_id_r[IW'(i_r)];
      S_IDL_CHK: begin
        mem_waddr = pend_id_r[IW'(i_r)];
        if (mem_rdata.start <= now_r && now_r <= mem_rdata.finish) begin
          mem_we = 1'b1;
          if (mem_rdata.idle != cpps_pkg::TICK_MAX) mem_wdata.idle = mem_rdata.idle + 1'b1;
          if (mem_rdata.finish != cpps_pkg::TICK_MAX)
            mem_wdata.finish = mem_rdata.finish + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // the tick just processed, kept for the finished test
  logic [11:0] tick_r;
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) tick_r <= now_r;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      i_r <= '0;
      cap_r <= cpps_pkg::CAP_RESET;
      tcnt_r <= 5'd16;
      run_cnt_r <= '0;
      pend_cnt_r <= '0;
      load_r <= '0;
      now_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cpps_pkg::REG_CAPACITY) cap_r <= cfg_data;
        else tcnt_r <= cfg_data[4:0];
      end
      if (out_valid_r && out_ready && state_r != S_OUT_SEND) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          i_r <= i_r + 1'b1;
          if (32'(i_r) == MAX_TASKS - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.operation == cpps_pkg::OP_LOAD) begin
              key_id_r <= IW'(in_data.task_id);
              ld_r <= in_data;
              if (32'(in_data.task_id) < MAX_TASKS) state_r <= S_LD_WR;
            end else begin
              ws_r <= ws_c;
              i_r <= '0;
              alive_r <= 1'b0;
              state_r <= S_ALV_RD;
            end
          end
        end
        // a reloaded runner keeps its cached priority current
        S_LD_WR: begin
          for (int k = 0; k < MAX_TASKS; k++) begin
            if (k < 32'(run_cnt_r) && run_id_r[k] == key_id_r)
              run_pr_r[k] <= ld_r.priority_req;
          end
          state_r <= S_IDLE;
        end
        // any task with finish at or after now
        S_ALV_RD: state_r <= S_ALV_CHK;
        S_ALV_CHK: begin
          if (now_r <= mem_rdata.finish) alive_r <= 1'b1;
          if (i_r + 1'b1 == LCW'(ws_r)) begin
            if (alive_r || now_r <= mem_rdata.finish) begin
              i_r <= LCW'(run_cnt_r);
              state_r <= S_RET_RD;
            end else begin
              i_r <= '0;
              state_r <= S_OUT_RD;
            end
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= S_ALV_RD;
          end
        end
        // retire runners from the top down
        S_RET_RD: begin
          if (i_r == '0) begin
            i_r <= '0;
            cand_cnt_r <= '0;
            state_r <= S_CND_PEND;
          end else begin
            state_r <= S_RET_CHK;
          end
        end
        S_RET_CHK: begin
          if (mem_rdata.finish < now_r) begin
            load_r <= load_r - 32'(run_pr_r[IW'(i_r - 1'b1)]);
            run_id_r[IW'(i_r - 1'b1)] <= run_id_r[IW'(run_cnt_r - 1'b1)];
            run_pr_r[IW'(i_r - 1'b1)] <= run_pr_r[IW'(run_cnt_r - 1'b1)];
            run_cnt_r <= run_cnt_r - 1'b1;
          end
          i_r <= i_r - 1'b1;
          state_r <= S_RET_RD;
        end
        // candidates: pending list, priorities fetched per entry during sort
        S_CND_PEND: begin
          if (i_r == LCW'(pend_cnt_r)) begin
            i_r <= LCW'(ws_r);
            state_r <= S_CND_RD;
          end else begin
            cand_id_r[LW'(cand_cnt_r)] <= pend_id_r[IW'(i_r)];
            cand_cnt_r <= cand_cnt_r + 1'b1;
            i_r <= i_r + 1'b1;
          end
        end
        // arrivals in descending id order; priorities looked up during sort
        S_CND_RD: begin
          if (i_r == '0) begin
            i_r <= '0;
            state_r <= S_SRT_I;
          end else begin
            i_r <= i_r - 1'b1;
            state_r <= S_CND_CHK;
          end
        end
        S_CND_CHK: begin
          if (mem_rdata.start == now_r) begin
            cand_id_r[LW'(cand_cnt_r)] <= cur_id;
            cand_cnt_r <= cand_cnt_r + 1'b1;
          end
          state_r <= S_CND_RD;
        end
        // fetch priority of every candidate, then insertion sort
        S_SRT_I: begin
          if (i_r == cand_cnt_r) begin
            i_r <= LCW'(1);
            state_r <= S_SRT_KEY;
          end else begin
            state_r <= S_SRT_RD;
          end
        end
        S_SRT_RD: begin
          cand_pr_r[LW'(i_r)] <= mem_rdata.prio;
          i_r <= i_r + 1'b1;
          state_r <= S_SRT_I;
        end
        S_SRT_KEY: begin
          if (i_r >= cand_cnt_r) begin
            i_r <= '0;
            state_r <= S_ADM_RD;
          end else begin
            key_id_r <= cand_id_r[LW'(i_r)];
            key_pr_r <= cand_pr_r[LW'(i_r)];
            j_r <= i_r;
            state_r <= S_SRT_CMP;
          end
        end
        S_SRT_CMP: begin
          if (j_r != '0 && cand_pr_r[LW'(j_r - 1'b1)] < key_pr_r) begin
            cand_id_r[LW'(j_r)] <= cand_id_r[LW'(j_r - 1'b1)];
            cand_pr_r[LW'(j_r)] <= cand_pr_r[LW'(j_r - 1'b1)];
            j_r <= j_r - 1'b1;
          end else begin
            cand_id_r[LW'(j_r)] <= key_id_r;
            cand_pr_r[LW'(j_r)] <= key_pr_r;
            i_r <= i_r + 1'b1;
            state_r <= S_SRT_KEY;
          end
        end
        // admission of each candidate
        S_ADM_RD: begin
          if (i_r == cand_cnt_r) begin
            i_r <= '0;
            state_r <= S_IDL_RD;
          end else begin
            state_r <= S_ADM_CHK;
          end
        end
        S_ADM_CHK: begin
          key_id_r <= cand_cur;
          key_pr_r <= mem_rdata.prio;
          if (mem_rdata.start > now_r || mem_rdata.finish < now_r || cur_running) begin
            i_r <= i_r + 1'b1;
            state_r <= S_ADM_RD;
          end else begin
            if (cur_pending) begin
              pend_id_r[IW'(cur_pend_pos)] <= pend_id_r[IW'(pend_cnt_r - 1'b1)];
              pend_cnt_r <= pend_cnt_r - 1'b1;
            end
            state_r <= S_ADM_SCAN;
          end
        end
        S_ADM_SCAN: begin
          if (need > 32'(cap_r)) begin
            if (run_cnt_r == '0) begin
              state_r <= S_ADM_EVICT;
              vic_pr_r <= key_pr_r;
            end else begin
              vic_pos_r <= '0;
              vic_id_r <= run_id_r[0];
              vic_pr_r <= run_pr_r[0];
              j_r <= LCW'(1);
              state_r <= S_ADM_SCMP;
            end
          end else if (32'(run_cnt_r) >= MAX_TASKS) begin
            vic_pr_r <= key_pr_r;
            state_r <= S_ADM_EVICT;
          end else begin
            run_id_r[IW'(run_cnt_r)] <= key_id_r;
            run_pr_r[IW'(run_cnt_r)] <= key_pr_r;
            run_cnt_r <= run_cnt_r + 1'b1;
            load_r <= need;
            i_r <= i_r + 1'b1;
            state_r <= S_ADM_RD;
          end
        end
        // weakest runner scan, one entry a cycle
        S_ADM_SCMP: begin
          if (j_r == LCW'(run_cnt_r)) begin
            state_r <= S_ADM_SRD;
          end else begin
            if (run_pr_r[IW'(j_r)] < vic_pr_r ||
                (run_pr_r[IW'(j_r)] == vic_pr_r && run_id_r[IW'(j_r)] > vic_id_r)) begin
              vic_pos_r <= CW'(j_r);
              vic_id_r <= run_id_r[IW'(j_r)];
              vic_pr_r <= run_pr_r[IW'(j_r)];
            end
            j_r <= j_r + 1'b1;
          end
        end
        S_ADM_SRD: begin
          if (vic_pr_r >= key_pr_r) begin
            state_r <= S_ADM_EVICT;
          end else begin
            load_r <= load_r - 32'(vic_pr_r);
            run_id_r[IW'(vic_pos_r)] <= run_id_r[IW'(run_cnt_r - 1'b1)];
            run_pr_r[IW'(vic_pos_r)] <= run_pr_r[IW'(run_cnt_r - 1'b1)];
            run_cnt_r <= run_cnt_r - 1'b1;
            if (!vic_pending && 32'(pend_cnt_r) < MAX_TASKS) begin
              pend_id_r[IW'(pend_cnt_r)] <= vic_id_r;
              pend_cnt_r <= pend_cnt_r + 1'b1;
            end
            state_r <= S_ADM_SCAN;
          end
        end
        // failed: key joins pending list
        S_ADM_EVICT: begin
          if (!in_run(key_id_r, pend_cnt_r, pend_id_r) && 32'(pend_cnt_r) < MAX_TASKS) begin
            pend_id_r[IW'(pend_cnt_r)] <= key_id_r;
            pend_cnt_r <= pend_cnt_r + 1'b1;
          end
          i_r <= i_r + 1'b1;
          state_r <= S_ADM_RD;
        end
        // idle and finish extension of current pending tasks, then now advances
        S_IDL_RD: begin
          if (i_r == LCW'(pend_cnt_r)) begin
            i_r <= '0;
            if (now_r != cpps_pkg::TICK_MAX) now_r <= now_r + 1'b1;
            state_r <= S_OUT_RD;
          end else begin
            state_r <= S_IDL_CHK;
          end
        end
        S_IDL_CHK: begin
          i_r <= i_r + 1'b1;
          state_r <= S_IDL_RD;
        end
        // result rows
        S_OUT_RD: state_r <= S_OUT_WAIT;
        S_OUT_WAIT: state_r <= S_OUT_SEND;
        S_OUT_SEND: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_r.task_index <= 4'(i_r);
            if (row_running) out_r.task_state <= cpps_pkg::ST_RUN;
            else if (mem_rdata.finish < tick_r) out_r.task_state <= cpps_pkg::ST_DONE;
            else out_r.task_state <= cpps_pkg::ST_WAIT;
            out_r.current_finish <= mem_rdata.finish;
            out_r.idle_ticks <= mem_rdata.idle;
            out_r.load_now <= load_r[11:0];
            out_r.all_done <= !alive_r;
            out_r.last_row <= (i_r + 1'b1 == LCW'(ws_r));
            if (i_r + 1'b1 == LCW'(ws_r)) begin
              state_r <= S_IDLE;
            end else begin
              i_r <= i_r + 1'b1;
              state_r <= S_OUT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a stalled result row holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result row changed while stalled");

  // run list never exceeds table size
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(run_cnt_r) <= MAX_TASKS)
    else $error("run list overflow");

  // no input ready while a result row is being sent
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT_SEND) |-> !in_ready)
    else $error("input ready during output");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the capacity limited priority scheduler: task
// loads and ticks go in through a queue-fed driver, every tick's result rows
// are predicted by a local scheduler model and checked field by field by a
// clocked monitor, with random idling on both sides and several settings of
// capacity and task count
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NTASK = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  cpps_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cpps_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = cpps_pkg::REG_CAPACITY;
  logic [11:0] cfg_data = '0;

  capacity_priority_preempt_scheduler_top #(.MAX_TASKS(NTASK)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // stimulus and expectation stores
  cpps_pkg::in_item_t item_q[$];
  cpps_pkg::out_item_t row_q[$];
  int n_queued = 0;
  int n_taken = 0;
  int errors = 0;
  bit calm = 1'b0;
  bit in_took = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  // scheduler state mirror
  logic [7:0]  t_prio[NTASK];
  logic [11:0] t_start[NTASK];
  logic [11:0] t_fin[NTASK];
  logic [11:0] t_idle[NTASK];
  logic [3:0]  runners[NTASK];
  int          run_n = 0;
  logic [3:0]  waiters[NTASK];
  int          wait_n = 0;
  logic [31:0] load_sum = '0;
  logic [11:0] now_t = '0;
  logic [11:0] cap = cpps_pkg::CAP_RESET;
  logic [4:0]  tcount = 5'd16;

  initial begin
    for (int i = 0; i < NTASK; i++) t_idle[i] = '0;
  end

  function automatic void run_drop(int pos);
    load_sum -= 32'(t_prio[runners[pos]]);
    run_n--;
    runners[pos] = runners[run_n];
  endfunction

  function automatic bit is_runner(logic [3:0] id);
    for (int i = 0; i < run_n; i++) if (runners[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void wait_add(logic [3:0] id);
    for (int i = 0; i < wait_n; i++) if (waiters[i] == id) return;
    if (wait_n < NTASK) begin
      waiters[wait_n] = id;
      wait_n++;
    end
  endfunction

  function automatic void wait_del(logic [3:0] id);
    for (int i = 0; i < wait_n; i++) begin
      if (waiters[i] == id) begin
        wait_n--;
        waiters[i] = waiters[wait_n];
        return;
      end
    end
  endfunction

  // lowest priority runner, higher id on a tie
  function automatic int weakest_pos();
    int m = 0;
    for (int i = 1; i < run_n; i++) begin
      if (t_prio[runners[i]] < t_prio[runners[m]] ||
          (t_prio[runners[i]] == t_prio[runners[m]] && runners[i] > runners[m]))
        m = i;
    end
    return m;
  endfunction

  // summed load wraps at 32 bits
  function automatic bit try_admit(logic [3:0] id);
    logic [31:0] p;
    int m;
    logic [3:0] victim;
    p = 32'(t_prio[id]);
    while (load_sum + p > 32'(cap)) begin
      if (run_n == 0) return 1'b0;
      m = weakest_pos();
      victim = runners[m];
      if (32'(t_prio[victim]) >= p) return 1'b0;
      run_drop(m);
      wait_add(victim);
    end
    if (run_n >= NTASK) return 1'b0;
    runners[run_n] = id;
    run_n++;
    load_sum += p;
    return 1'b1;
  endfunction

  function automatic void schedule(logic [11:0] t, int ws);
    logic [3:0] cand[2*NTASK];
    logic [3:0] key;
    logic [3:0] id;
    int nc = 0;
    int j;
    for (int i = run_n; i > 0; i--)
      if (t_fin[runners[i-1]] < t) run_drop(i - 1);
    for (int k = 0; k < wait_n; k++) begin
      cand[nc] = waiters[k];
      nc++;
    end
    for (int i = ws; i > 0; i--) begin
      if (t_start[i-1] == t) begin
        cand[nc] = 4'(i - 1);
        nc++;
      end
    end
    // stable insertion sort, priority descending
    for (int i = 1; i < nc; i++) begin
      key = cand[i];
      j = i;
      while (j > 0 && t_prio[cand[j-1]] < t_prio[key]) begin
        cand[j] = cand[j-1];
        j--;
      end
      cand[j] = key;
    end
    for (int k = 0; k < nc; k++) begin
      id = cand[k];
      if (t_start[id] > t || t_fin[id] < t) continue;
      if (is_runner(id)) continue;
      wait_del(id);
      if (!try_admit(id)) wait_add(id);
    end
    // current waiting tasks age and slip
    for (int k = 0; k < wait_n; k++) begin
      id = waiters[k];
      if (t_start[id] <= t && t <= t_fin[id]) begin
        if (t_idle[id] < cpps_pkg::TICK_MAX) t_idle[id]++;
        if (t_fin[id] < cpps_pkg::TICK_MAX) t_fin[id]++;
      end
    end
  endfunction

  // apply one transfer and queue the rows it yields
  function automatic void predict_rows(cpps_pkg::in_item_t it);
    int ws;
    logic [11:0] t;
    bit alive = 1'b0;
    cpps_pkg::out_item_t r;
    if (it.operation == cpps_pkg::OP_LOAD) begin
      t_prio[it.task_id] = it.priority_req;
      t_start[it.task_id] = it.start_time;
      t_fin[it.task_id] = it.finish_time;
      t_idle[it.task_id] = '0;
      return;
    end
    ws = (tcount == 0) ? 1 : (tcount > NTASK) ? NTASK : int'(tcount);
    t = now_t;
    for (int i = 0; i < ws; i++) if (t <= t_fin[i]) alive = 1'b1;
    if (alive) begin
      schedule(t, ws);
      if (now_t < cpps_pkg::TICK_MAX) now_t++;
    end
    for (int i = 0; i < ws; i++) begin
      r.task_index = 4'(i);
      if (is_runner(4'(i))) r.task_state = cpps_pkg::ST_RUN;
      else if (t_fin[i] < t) r.task_state = cpps_pkg::ST_DONE;
      else r.task_state = cpps_pkg::ST_WAIT;
      r.current_finish = t_fin[i];
      r.idle_ticks = t_idle[i];
      r.load_now = load_sum[11:0];
      r.all_done = !alive;
      r.last_row = (i + 1 == ws);
      row_q.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [11:0] exp_v, logic [11:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // monitor: check row transfers, then predict accepted items
  always @(posedge clk) begin
    cpps_pkg::out_item_t e;
    in_took <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (row_q.size() == 0) begin
          $error("unexpected result row, task_index %0d", out_data.task_index);
          errors++;
        end else begin
          e = row_q.pop_front();
          check_field("task_index", e.task_index, out_data.task_index);
          check_field("task_state", e.task_state, out_data.task_state);
          check_field("current_finish", e.current_finish, out_data.current_finish);
          check_field("idle_ticks", e.idle_ticks, out_data.idle_ticks);
          check_field("load_now", e.load_now, out_data.load_now);
          check_field("all_done", e.all_done, out_data.all_done);
          check_field("last_row", e.last_row, out_data.last_row);
        end
      end
      if (in_valid && in_ready) begin
        predict_rows(in_data);
        n_taken++;
      end
    end
  end

  // input driver with idle bursts
  always @(negedge clk) begin
    logic nv;
    cpps_pkg::in_item_t nd;
    nv = in_valid;
    nd = in_data;
    if (rst_n && !(in_valid && !in_took)) begin
      nv = 1'b0;
      if (in_gap > 0) in_gap--;
      else if (item_q.size() > 0) begin
        if (!calm && $urandom_range(0, 6) == 0) in_gap = $urandom_range(1, 9) - 1;
        else begin
          nd = item_q.pop_front();
          nv = 1'b1;
        end
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // result side back-pressure
  always @(negedge clk) begin
    logic nr;
    nr = 1'b1;
    if (out_gap > 0) begin
      out_gap--;
      nr = 1'b0;
    end else if (!calm && $urandom_range(0, 8) == 0) begin
      out_gap = $urandom_range(1, 9) - 1;
      nr = 1'b0;
    end
    out_ready <= rst_n ? nr : 1'b0;
  end

  task automatic push_load(logic [3:0] id, logic [7:0] p, logic [11:0] s, logic [11:0] f);
    cpps_pkg::in_item_t it;
    it.operation = cpps_pkg::OP_LOAD;
    it.task_id = id;
    it.priority_req = p;
    it.start_time = s;
    it.finish_time = f;
    item_q.push_back(it);
    n_queued++;
  endtask

  // tick with junk in the unused fields
  task automatic push_tick();
    cpps_pkg::in_item_t it;
    it.operation = cpps_pkg::OP_TICK;
    it.task_id = 4'($urandom);
    it.priority_req = 8'($urandom);
    it.start_time = 12'($urandom);
    it.finish_time = 12'($urandom);
    item_q.push_back(it);
    n_queued++;
  endtask

  task automatic write_reg(logic idx, logic [11:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == cpps_pkg::REG_CAPACITY) cap = val;
    else tcount = val[4:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    wait (n_taken == n_queued && row_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // well-formed task sets near the current tick, some noise loads
  task automatic random_phase(int nticks);
    logic [11:0] s;
    for (int i = 0; i < NTASK; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_load(4'(i), 8'($urandom), 12'($urandom), 12'($urandom));
      end else begin
        s = now_t + 12'($urandom_range(0, 6));
        push_load(4'(i), ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30)),
                  s, s + 12'($urandom_range(0, 12)));
      end
    end
    for (int k = 0; k < nticks; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        s = now_t + 12'($urandom_range(0, 4));
        push_load(4'($urandom), 8'($urandom_range(0, 40)), s, s + 12'($urandom_range(0, 8)));
      end
      push_tick();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, ties, preemption, saturating finish
    push_load(4'd0, 8'd255, 12'd0, 12'd4095);
    push_load(4'd1, 8'd0, 12'd0, 12'd0);
    push_load(4'd2, 8'd10, 12'd0, 12'd3);
    push_load(4'd3, 8'd10, 12'd0, 12'd3);
    push_load(4'd4, 8'd15, 12'd1, 12'd5);
    for (int i = 5; i < 15; i++) push_load(4'(i), 8'(i), 12'd2, 12'(i));
    push_load(4'd15, 8'd5, 12'd4095, 12'd4095);
    repeat (6) push_tick();
    settle();

    // all done with a single task slot
    write_reg(cpps_pkg::REG_TASK_COUNT, 12'd0);
    push_load(4'd0, 8'd1, 12'd0, 12'd0);
    repeat (2) push_tick();
    settle();

    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 7)
        0: write_reg(cpps_pkg::REG_CAPACITY, 12'd0);
        1: write_reg(cpps_pkg::REG_CAPACITY, 12'd4095);
        2: write_reg(cpps_pkg::REG_CAPACITY, cpps_pkg::CAP_RESET);
        default: write_reg(cpps_pkg::REG_CAPACITY, 12'($urandom_range(5, 120)));
      endcase
      case (ph % 5)
        0: write_reg(cpps_pkg::REG_TASK_COUNT, 12'd16);
        1: write_reg(cpps_pkg::REG_TASK_COUNT, 12'd1);
        2: write_reg(cpps_pkg::REG_TASK_COUNT, {7'($urandom), 5'd31});
        default: write_reg(cpps_pkg::REG_TASK_COUNT, 12'($urandom_range(2, 16)));
      endcase
      if (ph == 13) calm = 1'b1;
      random_phase(13);
      settle();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #50000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
src/cpps_pkg.sv
src/cpps_ram.sv
src/capacity_priority_preempt_scheduler_top.sv
test/tb_top.sv
